// ===== src/ulsdc_pkg.sv =====
`timescale 1ns / 1ps

package ulsdc_pkg;

  // Sequencer phases of one measurement and dispense cycle.
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_TRIG_LOW  = 3'd1,
    PH_TRIG_HIGH = 3'd2,
    PH_WAIT_RISE = 3'd3,
    PH_WAIT_FALL = 3'd4,
    PH_PUMP      = 3'd5
  } phase_t;

  // Request kinds carried on the input tuser.
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_THRESHOLD     = 2'd0;
  localparam logic [1:0] REG_ECHO_TIMEOUT  = 2'd1;
  localparam logic [1:0] REG_PUMP_TIME     = 2'd2;
  localparam logic [1:0] REG_TRIGGER_WIDTH = 2'd3;

  localparam int CFG_DATA_W = 22;

  // Reset values of the configuration registers.
  localparam logic [11:0] THRESHOLD_RST     = 12'd14;
  localparam logic [15:0] ECHO_TIMEOUT_RST  = 16'd30000;
  localparam logic [21:0] PUMP_TIME_RST     = 22'd3000000;
  localparam logic [7:0]  TRIGGER_WIDTH_RST = 8'd10;

  // Trigger is held low for this many ticks before the high pulse.
  localparam logic [22:0] TRIG_LOW_TICKS = 23'd2;

  // Distance: floor((40*w + 2494) / 580), done as a multiply by
  // ceil(2^32 / 580), which is exact for numerators below 2^22.
  localparam logic [21:0] DIST_OFFSET = 22'd2494;
  localparam logic [22:0] DIST_RECIP  = 23'd7405117;
  localparam logic [11:0] DIST_MAX    = 12'd4095;

  typedef struct packed {
    logic [11:0] threshold_cm;
    logic [15:0] echo_timeout_us;
    logic [21:0] pump_time_us;
    logic [7:0]  trigger_width_us;
  } cfg_t;

  typedef struct packed {
    logic        busy_res;
    logic        available;
    logic        timed_out;
    logic [11:0] range_cm;
    logic        done_res;
    logic        pump_two;
    logic        pump_one;
    logic        trigger_two;
    logic        trigger_one;
  } result_t;

endpackage

// ===== src/ultrasonic_level_dispense_control_unit.sv =====
`timescale 1ns / 1ps

// Two-channel ultrasonic level check with pump dispense. Each input request is
// either a one-microsecond tick carrying the sampled echo level or a start
// naming a channel; every request gives exactly one result holding the
// trigger and pump line levels, a done pulse with distance, timeout and
// availability, and a busy flag. A request is taken every clock cycle while
// the result side is not stalled: the sequencer state and the result are
// computed in one pass and land in the output register, which is reloaded in
// the same cycle it is drained. The longest path is the constant-reciprocal
// multiply for the distance followed by the threshold compare. Configuration
// writes take effect on the next request.
module ultrasonic_level_dispense_control_unit (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration write port.
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [ulsdc_pkg::CFG_DATA_W-1:0] cfg_data,
  // Input stream.
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,  // [0] channel, [1] echo_level
  input  logic                             s_tuser,  // [0] operation
  // Result stream.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [0] trigger_one, [1] trigger_two, [2] pump_one, [3] pump_two, [4] done_res,
  // [16:5] range_cm, [17] timed_out, [18] available, [19] busy_res
  output logic [23:0]                      m_tdata
);
  import ulsdc_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    accept;

  // The output register frees up in the same cycle it is read.
  assign s_tready = ~m_tvalid | m_tready;
  assign accept   = s_tvalid & s_tready;

  ulsdc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ulsdc_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .operation  (s_tuser),
    .channel    (s_tdata[0]),
    .echo_level (s_tdata[1]),
    .cfg        (cfg),
    .res        (res)
  );

  // Result register and its valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {4'b0, res.busy_res, res.available, res.timed_out, res.range_cm,
                  res.done_res, res.pump_two, res.pump_one, res.trigger_two,
                  res.trigger_one};
    end
  end

endmodule

// ===== src/ulsdc_cfg.sv =====
`timescale 1ns / 1ps

module ulsdc_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [ulsdc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output ulsdc_pkg::cfg_t                    cfg
);
  import ulsdc_pkg::*;

  // Register file; each write takes the low bits that the register holds.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_cm     <= THRESHOLD_RST;
      cfg.echo_timeout_us  <= ECHO_TIMEOUT_RST;
      cfg.pump_time_us     <= PUMP_TIME_RST;
      cfg.trigger_width_us <= TRIGGER_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD:     cfg.threshold_cm     <= cfg_data[11:0];
        REG_ECHO_TIMEOUT:  cfg.echo_timeout_us  <= cfg_data[15:0];
        REG_PUMP_TIME:     cfg.pump_time_us     <= cfg_data[21:0];
        REG_TRIGGER_WIDTH: cfg.trigger_width_us <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/ulsdc_dist.sv =====
`timescale 1ns / 1ps

module ulsdc_dist (
  input  logic [16:0] width,
  output logic [11:0] range_cm
);
  import ulsdc_pkg::*;

  logic [21:0] numer;
  logic [44:0] prod;
  logic [12:0] quot;

  // 40*w + 2494 built from shifts; the result stays below 2^22.
  assign numer = {width, 5'b0} + 22'({width, 3'b0}) + DIST_OFFSET;

  // Constant reciprocal multiply gives the exact quotient by 580.
  assign prod = 45'(numer) * 45'(DIST_RECIP);
  assign quot = prod[44:32];

  // Saturate to the width of the distance field.
  assign range_cm = (quot > 13'(DIST_MAX)) ? DIST_MAX : quot[11:0];

endmodule

// ===== src/ulsdc_seq.sv =====
`timescale 1ns / 1ps

module ulsdc_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               operation,
  input  logic               channel,
  input  logic               echo_level,
  input  ulsdc_pkg::cfg_t    cfg,
  output ulsdc_pkg::result_t res
);
  import ulsdc_pkg::*;

  phase_t      phase, phase_next;
  logic [21:0] tick_counter, tick_counter_next;
  logic [15:0] echo_width, echo_width_next;
  logic        active_channel, active_channel_next;

  logic [22:0] cnt_inc;
  logic [16:0] width_inc;
  logic [11:0] width_cm;
  logic        done, tmo, avail;
  logic [11:0] meas_cm;
  logic        trig, pump;

  assign cnt_inc   = 23'(tick_counter) + 23'd1;
  assign width_inc = 17'(echo_width) + 17'd1;

  ulsdc_dist u_dist (
    .width    (width_inc),
    .range_cm (width_cm)
  );

  // Next state and the result of the current request.
  always_comb begin
    phase_next          = phase;
    tick_counter_next   = tick_counter;
    echo_width_next     = echo_width;
    active_channel_next = active_channel;
    done    = 1'b0;
    tmo     = 1'b0;
    avail   = 1'b0;
    meas_cm = '0;

    if (operation == OP_START) begin
      // A start is taken only when idle.
      if (phase == PH_IDLE) begin
        active_channel_next = channel;
        phase_next          = PH_TRIG_LOW;
        tick_counter_next   = '0;
        echo_width_next     = '0;
      end
    end else begin
      unique case (phase)
        PH_TRIG_LOW: begin
          if (cnt_inc >= TRIG_LOW_TICKS) begin
            phase_next        = PH_TRIG_HIGH;
            tick_counter_next = '0;
          end else begin
            tick_counter_next = cnt_inc[21:0];
          end
        end
        PH_TRIG_HIGH: begin
          if (cnt_inc >= 23'(cfg.trigger_width_us)) begin
            phase_next        = PH_WAIT_RISE;
            tick_counter_next = '0;
          end else begin
            tick_counter_next = cnt_inc[21:0];
          end
        end
        PH_WAIT_RISE: begin
          if (echo_level) begin
            phase_next        = PH_WAIT_FALL;
            echo_width_next   = '0;
            tick_counter_next = '0;
          end else if (cnt_inc > 23'(cfg.echo_timeout_us)) begin
            done              = 1'b1;
            tmo               = 1'b1;
            phase_next        = PH_IDLE;
            tick_counter_next = '0;
          end else begin
            tick_counter_next = cnt_inc[21:0];
          end
        end
        PH_WAIT_FALL: begin
          tick_counter_next = '0;
          if (echo_level) begin
            if (width_inc > 17'(cfg.echo_timeout_us)) begin
              done       = 1'b1;
              tmo        = 1'b1;
              phase_next = PH_IDLE;
            end else begin
              echo_width_next = width_inc[15:0];
            end
          end else begin
            // Echo has ended: decide and start the pump if the tank is near.
            done    = 1'b1;
            meas_cm = width_cm;
            if (width_cm < cfg.threshold_cm) begin
              avail      = 1'b1;
              phase_next = PH_PUMP;
            end else begin
              phase_next = PH_IDLE;
            end
          end
        end
        PH_PUMP: begin
          if (cnt_inc >= 23'(cfg.pump_time_us)) begin
            phase_next        = PH_IDLE;
            tick_counter_next = '0;
          end else begin
            tick_counter_next = cnt_inc[21:0];
          end
        end
        default: begin
          phase_next        = PH_IDLE;
          tick_counter_next = '0;
        end
      endcase
    end
  end

  // Line levels follow the state after this request.
  assign trig = (phase_next == PH_TRIG_HIGH);
  assign pump = (phase_next == PH_PUMP);

  assign res.trigger_one = trig & ~active_channel_next;
  assign res.trigger_two = trig & active_channel_next;
  assign res.pump_one    = pump & ~active_channel_next;
  assign res.pump_two    = pump & active_channel_next;
  assign res.done_res    = done;
  assign res.range_cm    = meas_cm;
  assign res.timed_out   = tmo;
  assign res.available   = avail;
  assign res.busy_res    = (phase_next != PH_IDLE);

  // State registers advance on each accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      tick_counter   <= '0;
      echo_width     <= '0;
      active_channel <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      tick_counter   <= tick_counter_next;
      echo_width     <= echo_width_next;
      active_channel <= active_channel_next;
    end
  end

endmodule

// ===== tb/ultrasonic_level_dispense_control_unit_tb.sv =====
`timescale 1ns / 1ps

module ultrasonic_level_dispense_control_unit_tb;

  import ulsdc_pkg::*;

  localparam int unsigned RUN_LIMIT_NS = 50_000_000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [7:0]            s_tdata;  // [0] channel, [1] echo_level
  logic                  s_tuser;  // [0] operation
  logic                  m_tvalid;
  logic                  m_tready;
  // [0] trigger_one, [1] trigger_two, [2] pump_one, [3] pump_two, [4] done_res,
  // [16:5] range_cm, [17] timed_out, [18] available, [19] busy_res
  logic [23:0]           m_tdata;

  ultrasonic_level_dispense_control_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // Local copy of the sequencer state and of the register file.
  phase_t      seq_phase;
  int unsigned seq_ticks;
  int unsigned pulse_count;
  logic        seq_chan;
  cfg_t        regs;

  // Line levels still owed by the block, oldest first.
  result_t     due_levels[$];

  bit          feed_gaps;
  bit          sink_gaps;
  int unsigned sink_hold;
  int unsigned useful_items;
  int unsigned results_seen;
  int unsigned mismatch_count;

  // One row of the directed sequence: either a register write or a request
  // repeated a number of times, optionally with its last result typed in.
  typedef struct {
    bit          is_write;
    logic [1:0]  reg_idx;
    int unsigned reg_val;
    logic        op;
    logic        ch;
    logic        echo;
    int unsigned reps;
    bit          typed;
    result_t     want;
  } plan_row_t;

  plan_row_t plan[$];

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard limit on the length of the run.
  initial begin
    #(RUN_LIMIT_NS);
    $display("ultrasonic_level_dispense_control_unit regression: fail");
    $finish;
  end

  task automatic log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("MISMATCH: %s", msg);
  endtask

  task automatic match_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      log_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                             results_seen, name, got, want));
  endtask

  function automatic result_t levels(input bit trig_a, input bit trig_b,
                                     input bit pump_a, input bit pump_b,
                                     input bit done, input int unsigned cm,
                                     input bit tmo, input bit avail,
                                     input bit busy);
    result_t r;
    r.trigger_one = trig_a;
    r.trigger_two = trig_b;
    r.pump_one    = pump_a;
    r.pump_two    = pump_b;
    r.done_res    = done;
    r.range_cm    = cm[11:0];
    r.timed_out   = tmo;
    r.available   = avail;
    r.busy_res    = busy;
    return r;
  endfunction

  task automatic reset_levels();
    seq_phase             = PH_IDLE;
    seq_ticks             = 0;
    pulse_count           = 0;
    seq_chan              = 1'b0;
    regs.threshold_cm     = THRESHOLD_RST;
    regs.echo_timeout_us  = ECHO_TIMEOUT_RST;
    regs.pump_time_us     = PUMP_TIME_RST;
    regs.trigger_width_us = TRIGGER_WIDTH_RST;
  endtask

  // Advances the local sequencer by one request and returns the line levels
  // the block should show afterwards.
  function automatic result_t next_line_levels(input logic op, input logic ch,
                                               input logic echo);
    result_t     r;
    int unsigned e;
    int unsigned cm;
    r = '0;
    if (op == OP_START) begin
      // A start is taken only when idle and is not itself a tick.
      if (seq_phase == PH_IDLE) begin
        seq_chan    = ch;
        seq_phase   = PH_TRIG_LOW;
        seq_ticks   = 0;
        pulse_count = 0;
      end
    end else begin
      case (seq_phase)
        PH_IDLE: begin
        end
        PH_TRIG_LOW: begin
          seq_ticks++;
          if (seq_ticks >= TRIG_LOW_TICKS) begin
            seq_phase = PH_TRIG_HIGH;
            seq_ticks = 0;
          end
        end
        PH_TRIG_HIGH: begin
          seq_ticks++;
          if (seq_ticks >= regs.trigger_width_us) begin
            seq_phase = PH_WAIT_RISE;
            seq_ticks = 0;
          end
        end
        PH_WAIT_RISE: begin
          if (echo) begin
            seq_phase   = PH_WAIT_FALL;
            pulse_count = 0;
            seq_ticks   = 0;
          end else begin
            seq_ticks++;
            if (seq_ticks > regs.echo_timeout_us) begin
              r.done_res  = 1'b1;
              r.timed_out = 1'b1;
              seq_phase   = PH_IDLE;
              seq_ticks   = 0;
            end
          end
        end
        PH_WAIT_FALL: begin
          e = pulse_count + 1;
          if (echo) begin
            if (e > regs.echo_timeout_us) begin
              r.done_res  = 1'b1;
              r.timed_out = 1'b1;
              seq_phase   = PH_IDLE;
            end else begin
              pulse_count = e & 32'hFFFF;
            end
          end else begin
            // Pulse over: 40 * width / 580 with the 4.3 cm offset folded in.
            cm = (40 * e + 2494) / 580;
            if (cm > 4095) cm = 4095;
            r.done_res = 1'b1;
            r.range_cm = cm[11:0];
            if (cm < regs.threshold_cm) begin
              r.available = 1'b1;
              seq_phase   = PH_PUMP;
            end else begin
              seq_phase = PH_IDLE;
            end
          end
          seq_ticks = 0;
        end
        PH_PUMP: begin
          seq_ticks++;
          if (seq_ticks >= regs.pump_time_us) begin
            seq_phase = PH_IDLE;
            seq_ticks = 0;
          end
        end
        default: begin
          seq_phase = PH_IDLE;
          seq_ticks = 0;
        end
      endcase
    end
    r.trigger_one = (seq_phase == PH_TRIG_HIGH) && !seq_chan;
    r.trigger_two = (seq_phase == PH_TRIG_HIGH) && seq_chan;
    r.pump_one    = (seq_phase == PH_PUMP) && !seq_chan;
    r.pump_two    = (seq_phase == PH_PUMP) && seq_chan;
    r.busy_res    = (seq_phase != PH_IDLE);
    return r;
  endfunction

  // Offers one request and records what it should produce once accepted.
  task automatic send_req(input logic op, input logic ch, input logic echo,
                          input bit typed, input result_t want);
    result_t r;
    cfg_we <= 1'b0;
    while (feed_gaps && $urandom_range(99) < 30) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'd0, echo, ch};
    do @(posedge clk); while (!s_tready);
    r = next_line_levels(op, ch, echo);
    due_levels.push_back(typed ? want : r);
    if (r.busy_res || r.done_res) useful_items++;
  endtask

  // Stops offering and waits for every owed result.
  task automatic drain_levels();
    s_tvalid <= 1'b0;
    while (due_levels.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    case (idx)
      REG_THRESHOLD:     regs.threshold_cm     = val[11:0];
      REG_ECHO_TIMEOUT:  regs.echo_timeout_us  = val[15:0];
      REG_PUMP_TIME:     regs.pump_time_us     = val[21:0];
      REG_TRIGGER_WIDTH: regs.trigger_width_us = val[7:0];
      default: begin
      end
    endcase
  endtask

  task automatic plan_write(input logic [1:0] idx, input int unsigned val);
    plan_row_t row;
    row          = '{default: '0};
    row.is_write = 1'b1;
    row.reg_idx  = idx;
    row.reg_val  = val;
    plan.push_back(row);
  endtask

  task automatic plan_req(input logic op, input logic ch, input logic echo,
                          input int unsigned reps);
    plan_row_t row;
    row      = '{default: '0};
    row.op   = op;
    row.ch   = ch;
    row.echo = echo;
    row.reps = reps;
    plan.push_back(row);
  endtask

  task automatic plan_chk(input logic op, input logic ch, input logic echo,
                          input int unsigned reps, input result_t want);
    plan_row_t row;
    row       = '{default: '0};
    row.op    = op;
    row.ch    = ch;
    row.echo  = echo;
    row.reps  = reps;
    row.typed = 1'b1;
    row.want  = want;
    plan.push_back(row);
  endtask

  // One start followed by ticks until the sequencer is idle again. The echo
  // follows a planned pulse, with stray starts and the odd glitch mixed in.
  task automatic run_measurement();
    int unsigned lim;
    int unsigned rise_at;
    int unsigned hold_for;
    logic        echo;
    lim      = regs.echo_timeout_us;
    rise_at  = ($urandom_range(5) == 0) ? lim + 1 : $urandom_range(lim < 30 ? lim : 30);
    hold_for = ($urandom_range(5) == 0) ? lim + 1 : $urandom_range(lim);
    send_req(OP_START, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, '0);
    while (seq_phase != PH_IDLE) begin
      if ($urandom_range(15) == 0) begin
        send_req(OP_START, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, '0);
      end else begin
        case (seq_phase)
          PH_WAIT_RISE: echo = (seq_ticks >= rise_at);
          PH_WAIT_FALL: echo = (pulse_count < hold_for);
          default:      echo = 1'($urandom_range(1));
        endcase
        if ($urandom_range(19) == 0) echo = ~echo;
        send_req(OP_TICK, 1'($urandom_range(1)), echo, 1'b0, '0);
      end
    end
  endtask

  // Result side: checks every accepted result and paces m_tready.
  initial begin : result_sink
    result_t got;
    result_t want;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        results_seen++;
        got = m_tdata[19:0];
        if (due_levels.size() == 0) begin
          log_mismatch($sformatf("result %0d arrived with nothing expected",
                                 results_seen));
        end else begin
          want = due_levels.pop_front();
          match_field("trigger_one", got.trigger_one, want.trigger_one);
          match_field("trigger_two", got.trigger_two, want.trigger_two);
          match_field("pump_one", got.pump_one, want.pump_one);
          match_field("pump_two", got.pump_two, want.pump_two);
          match_field("done_res", got.done_res, want.done_res);
          match_field("range_cm", got.range_cm, want.range_cm);
          match_field("timed_out", got.timed_out, want.timed_out);
          match_field("available", got.available, want.available);
          match_field("busy_res", got.busy_res, want.busy_res);
          match_field("padding", m_tdata[23:20], 0);
        end
      end
      // A requested hold-off takes priority over random stalls.
      if (sink_hold > 0) begin
        sink_hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !(sink_gaps && $urandom_range(99) < 30);
      end
    end
  end

  // Stimulus.
  initial begin : stimulus
    int unsigned p;
    int unsigned k;
    int unsigned lim;
    int unsigned phase_start;
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_THRESHOLD;
    cfg_data     <= '0;
    s_tvalid     <= 1'b0;
    s_tdata      <= '0;
    s_tuser      <= OP_TICK;
    feed_gaps    = 1'b1;
    sink_gaps    = 1'b1;
    sink_hold    = 0;
    useful_items = 0;
    results_seen = 0;
    mismatch_count = 0;
    reset_levels();

    // Reset settings: one reading exactly at the threshold on channel one,
    // then, with a short echo timeout, a missing echo on channel two.
    plan_chk(OP_TICK,  1'b0, 1'b1, 1, levels(0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan_chk(OP_START, 1'b0, 1'b1, 1, levels(0, 0, 0, 0, 0, 0, 0, 0, 1));
    plan_req(OP_START, 1'b1, 1'b0, 1);
    plan_req(OP_TICK,  1'b1, 1'b1, 1);
    plan_chk(OP_TICK,  1'b1, 1'b0, 1, levels(1, 0, 0, 0, 0, 0, 0, 0, 1));
    plan_chk(OP_TICK,  1'b0, 1'b1, 9, levels(1, 0, 0, 0, 0, 0, 0, 0, 1));
    plan_chk(OP_TICK,  1'b0, 1'b1, 1, levels(0, 0, 0, 0, 0, 0, 0, 0, 1));
    plan_req(OP_TICK,  1'b0, 1'b0, 5);
    plan_req(OP_TICK,  1'b1, 1'b1, 1);
    plan_req(OP_TICK,  1'b0, 1'b1, 140);
    plan_chk(OP_TICK,  1'b0, 1'b0, 1, levels(0, 0, 0, 0, 1, 14, 0, 0, 0));
    plan_chk(OP_TICK,  1'b1, 1'b1, 1, levels(0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan_write(REG_ECHO_TIMEOUT, 20);
    plan_req(OP_START, 1'b1, 1'b1, 1);
    plan_chk(OP_TICK,  1'b0, 1'b0, 2, levels(0, 1, 0, 0, 0, 0, 0, 0, 1));
    plan_req(OP_TICK,  1'b0, 1'b0, 10);
    plan_chk(OP_TICK,  1'b0, 1'b0, 20, levels(0, 0, 0, 0, 0, 0, 0, 0, 1));
    plan_chk(OP_TICK,  1'b0, 1'b0, 1, levels(0, 0, 0, 0, 1, 0, 1, 0, 0));

    // Zero trigger width, timeout and pump time; every reading is in range.
    plan_write(REG_TRIGGER_WIDTH, 0);
    plan_write(REG_ECHO_TIMEOUT, 0);
    plan_write(REG_PUMP_TIME, 0);
    plan_write(REG_THRESHOLD, 4095);
    plan_req(OP_START, 1'b0, 1'b0, 1);
    plan_chk(OP_TICK,  1'b0, 1'b0, 2, levels(1, 0, 0, 0, 0, 0, 0, 0, 1));
    plan_chk(OP_TICK,  1'b0, 1'b1, 1, levels(0, 0, 0, 0, 0, 0, 0, 0, 1));
    plan_chk(OP_TICK,  1'b0, 1'b0, 1, levels(0, 0, 0, 0, 1, 0, 1, 0, 0));
    plan_req(OP_START, 1'b1, 1'b1, 1);
    plan_req(OP_TICK,  1'b0, 1'b0, 3);
    plan_req(OP_TICK,  1'b0, 1'b1, 1);
    plan_chk(OP_TICK,  1'b0, 1'b1, 1, levels(0, 0, 0, 0, 1, 0, 1, 0, 0));
    plan_req(OP_START, 1'b1, 1'b0, 1);
    plan_req(OP_TICK,  1'b0, 1'b1, 4);
    plan_chk(OP_TICK,  1'b0, 1'b0, 1, levels(0, 0, 0, 1, 1, 4, 0, 1, 1));
    plan_chk(OP_TICK,  1'b0, 1'b1, 1, levels(0, 0, 0, 0, 0, 0, 0, 0, 0));

    // Largest settings: the longest trigger pulse, then a near reading that
    // is never available with a zero threshold.
    plan_write(REG_THRESHOLD, 0);
    plan_write(REG_ECHO_TIMEOUT, 65535);
    plan_write(REG_PUMP_TIME, 4194303);
    plan_write(REG_TRIGGER_WIDTH, 255);
    plan_req(OP_START, 1'b0, 1'b1, 1);
    plan_chk(OP_TICK,  1'b1, 1'b1, 2, levels(1, 0, 0, 0, 0, 0, 0, 0, 1));
    plan_chk(OP_TICK,  1'b1, 1'b0, 254, levels(1, 0, 0, 0, 0, 0, 0, 0, 1));
    plan_chk(OP_TICK,  1'b1, 1'b0, 1, levels(0, 0, 0, 0, 0, 0, 0, 0, 1));
    plan_req(OP_TICK,  1'b1, 1'b1, 1);
    plan_chk(OP_TICK,  1'b1, 1'b1, 5, levels(0, 0, 0, 0, 0, 0, 0, 0, 1));
    plan_chk(OP_TICK,  1'b1, 1'b0, 1, levels(0, 0, 0, 0, 1, 4, 0, 0, 0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        // Registers change only once the block has gone quiet.
        if (i == 0 || !plan[i - 1].is_write) drain_levels();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        for (k = 1; k <= plan[i].reps; k++)
          send_req(plan[i].op, plan[i].ch, plan[i].echo,
                   plan[i].typed && (k == plan[i].reps), plan[i].want);
      end
    end

    // Random phases, each with its own small settings so pumps stay short.
    for (p = 0; p < 6; p++) begin
      drain_levels();
      lim = ($urandom_range(3) == 0) ? $urandom_range(90, 41) : $urandom_range(40);
      write_reg(REG_THRESHOLD, $urandom_range(12));
      write_reg(REG_ECHO_TIMEOUT, lim);
      write_reg(REG_PUMP_TIME, $urandom_range(24));
      write_reg(REG_TRIGGER_WIDTH, $urandom_range(6));
      feed_gaps = (p != 4);
      sink_gaps = (p != 4);
      // Hold the result side off so the input backs up behind it.
      if (p == 2) sink_hold = 300;
      phase_start = useful_items;
      while (useful_items - phase_start < 20) begin
        repeat ($urandom_range(2))
          send_req(OP_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, '0);
        run_measurement();
      end
    end

    drain_levels();
    if (mismatch_count == 0) begin
      $display("ultrasonic_level_dispense_control_unit regression: pass");
    end else begin
      $display("ultrasonic_level_dispense_control_unit regression: fail");
    end
    $finish;
  end

endmodule
